// ===== rtl/core/tupc_pkg.sv =====
// ----------------------------------------------------------------------------
// tupc_pkg
// shared types and codes for the texture upload pixel converter
// ----------------------------------------------------------------------------
package tupc_pkg;

    localparam int ADDR_W     = 27;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int DIM_W      = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_FORMAT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_FORMAT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd6;

    // source layouts
    localparam logic [1:0] SRC_LUM  = 2'd0;
    localparam logic [1:0] SRC_RGB  = 2'd1;
    localparam logic [1:0] SRC_RGBA = 2'd2;

    // destination layouts
    localparam logic DST_LUM  = 1'b0;
    localparam logic DST_ARGB = 1'b1;

    localparam logic [7:0]  OPAQUE_ALPHA = 8'hff;
    // floor(s/3) == (s*683)>>11 for every sum of three bytes
    localparam logic [19:0] THIRD_MUL    = 20'd683;
    localparam int          THIRD_SHIFT  = 11;

    typedef struct packed {
        logic [1:0]       src_format;
        logic             dst_format;
        logic [DIM_W-1:0] region_width;
        logic [DIM_W-1:0] region_height;
        logic [11:0]      x_offset;
        logic [11:0]      y_offset;
        logic [14:0]      row_pitch;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        src_format:    SRC_RGBA,
        dst_format:    DST_ARGB,
        region_width:  13'd1,
        region_height: 13'd1,
        x_offset:      12'd0,
        y_offset:      12'd0,
        row_pitch:     15'd4
    };

endpackage

// ===== rtl/core/texture_upload_pixel_converter.sv =====
// ----------------------------------------------------------------------------
// texture_upload_pixel_converter
// converts source pixels to argb or luminance and addresses them in a texture
// ----------------------------------------------------------------------------
// One pixel beat is taken every clock cycle while the output side keeps up;
// each result passes through the input register, then the result register,
// before it is offered. Between the two registers lie the byte swizzle, the
// divide-by-three of the luminance average (a constant multiply) and the
// address multiply of row by row pitch, which sets the clock figure.
// Column and row counters step once per accepted beat and wrap after the
// last pixel of the region; configuration must only change while idle.
// ----------------------------------------------------------------------------
module texture_upload_pixel_converter #(
    parameter int MAX_DIM = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_write,
    input  logic [tupc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tupc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // pixel input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        byte_zero,
    input  logic [7:0]                        byte_one,
    input  logic [7:0]                        byte_two,
    input  logic [7:0]                        byte_three,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tupc_pkg::ADDR_W-1:0]       dest_address,
    output logic [7:0]                        out_zero,
    output logic [7:0]                        out_one,
    output logic [7:0]                        out_two,
    output logic [7:0]                        out_three,
    output logic                              wide_write,
    output logic                              region_done
);
    import tupc_pkg::*;

    // counter width follows the largest region
    localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // configuration registers
    cfg_t cfg_reg, cfg_next;

    // input stage
    logic          s1_valid_reg, s1_valid_next;
    logic [7:0]    s1_b0_reg, s1_b1_reg, s1_b2_reg, s1_b3_reg;
    logic [CW-1:0] s1_col_reg, s1_row_reg;
    logic          s1_last_reg;

    // result stage
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [7:0]        out_b0_reg, out_b1_reg, out_b2_reg, out_b3_reg;
    logic              out_wide_reg, out_done_reg;

    // handshake
    logic out_advance;
    logic s1_advance;
    logic in_accept;

    // walker and datapath
    logic [CW-1:0]     cur_col, cur_row;
    logic              cur_last;
    logic [ADDR_W-1:0] dp_addr;
    logic [7:0]        dp_o0, dp_o1, dp_o2, dp_o3;

    // register writes, unknown indexes dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_SRC_FORMAT:    cfg_next.src_format    = cfg_data[1:0];
                REG_DST_FORMAT:    cfg_next.dst_format    = cfg_data[0];
                REG_REGION_WIDTH:  cfg_next.region_width  = cfg_data[DIM_W-1:0];
                REG_REGION_HEIGHT: cfg_next.region_height = cfg_data[DIM_W-1:0];
                REG_X_OFFSET:      cfg_next.x_offset      = cfg_data[11:0];
                REG_Y_OFFSET:      cfg_next.y_offset      = cfg_data[11:0];
                REG_ROW_PITCH:     cfg_next.row_pitch     = cfg_data[14:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // result register frees when empty or taken this cycle
    assign out_advance = !out_valid_reg || !out_stall;
    // input register frees when empty or moving on
    assign s1_advance  = !s1_valid_reg || out_advance;
    assign in_stall    = !s1_advance;
    assign in_accept   = in_valid && s1_advance;

    assign s1_valid_next  = s1_advance ? in_valid : s1_valid_reg;
    assign out_valid_next = out_advance ? s1_valid_reg : out_valid_reg;

    // position is sampled at the beat that takes the pixel
    tupc_walker #(
        .MAX_DIM (MAX_DIM),
        .CW      (CW)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (in_accept),
        .region_width  (cfg_reg.region_width),
        .region_height (cfg_reg.region_height),
        .column        (cur_col),
        .row           (cur_row),
        .last_pixel    (cur_last)
    );

    tupc_datapath #(
        .CW (CW)
    ) u_datapath (
        .cfg    (cfg_reg),
        .b0     (s1_b0_reg),
        .b1     (s1_b1_reg),
        .b2     (s1_b2_reg),
        .b3     (s1_b3_reg),
        .column (s1_col_reg),
        .row    (s1_row_reg),
        .addr   (dp_addr),
        .o0     (dp_o0),
        .o1     (dp_o1),
        .o2     (dp_o2),
        .o3     (dp_o3)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_b0_reg   <= byte_zero;
            s1_b1_reg   <= byte_one;
            s1_b2_reg   <= byte_two;
            s1_b3_reg   <= byte_three;
            s1_col_reg  <= cur_col;
            s1_row_reg  <= cur_row;
            s1_last_reg <= cur_last;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_advance && s1_valid_reg)
        begin
            out_addr_reg <= dp_addr;
            out_b0_reg   <= dp_o0;
            out_b1_reg   <= dp_o1;
            out_b2_reg   <= dp_o2;
            out_b3_reg   <= dp_o3;
            out_wide_reg <= cfg_reg.dst_format;
            out_done_reg <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_address = out_addr_reg;
    assign out_zero     = out_b0_reg;
    assign out_one      = out_b1_reg;
    assign out_two      = out_b2_reg;
    assign out_three    = out_b3_reg;
    assign wide_write   = out_wide_reg;
    assign region_done  = out_done_reg;

endmodule

// ===== rtl/core/tupc_walker.sv =====
// ----------------------------------------------------------------------------
// tupc_walker
// column and row counters that walk the upload region
// ----------------------------------------------------------------------------
module tupc_walker #(
    parameter int MAX_DIM = 4096,
    parameter int CW      = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [tupc_pkg::DIM_W-1:0] region_width,
    input  logic [tupc_pkg::DIM_W-1:0] region_height,
    output logic [CW-1:0]             column,
    output logic [CW-1:0]             row,
    output logic                      last_pixel
);
    import tupc_pkg::*;

    localparam int VW = DIM_W + 1;
    localparam logic [VW-1:0] MAX_V = VW'(MAX_DIM);

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [VW-1:0] w_eff, h_eff;
    logic [VW-1:0] w_m1, h_m1;
    logic          last_col, last_row;

    // zero reads as one, oversize as the maximum
    always_comb
    begin
        if (region_width == '0)
            w_eff = VW'(1);
        else if (VW'(region_width) > MAX_V)
            w_eff = MAX_V;
        else
            w_eff = VW'(region_width);

        if (region_height == '0)
            h_eff = VW'(1);
        else if (VW'(region_height) > MAX_V)
            h_eff = MAX_V;
        else
            h_eff = VW'(region_height);
    end

    assign w_m1 = w_eff - VW'(1);
    assign h_m1 = h_eff - VW'(1);

    // at or past the end counts as the end
    assign last_col = VW'(col_reg) >= w_m1;
    assign last_row = VW'(row_reg) >= h_m1;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign column     = col_reg;
    assign row        = row_reg;
    assign last_pixel = last_col && last_row;

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_col |=> col_reg == '0)
        else $error("column did not wrap after last column");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last_col |=> col_reg == CW'($past(col_reg) + 1'b1)
            && $stable(row_reg))
        else $error("column step wrong");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(col_reg) && $stable(row_reg))
        else $error("counters moved without a beat");

    a_region_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_col && last_row |=> row_reg == '0)
        else $error("row did not wrap after last pixel");

endmodule

// ===== rtl/core/tupc_datapath.sv =====
// ----------------------------------------------------------------------------
// tupc_datapath
// pixel swizzle, luminance average and destination address
// ----------------------------------------------------------------------------
module tupc_datapath #(
    parameter int CW = 12
) (
    input  tupc_pkg::cfg_t                cfg,
    input  logic [7:0]                    b0,
    input  logic [7:0]                    b1,
    input  logic [7:0]                    b2,
    input  logic [7:0]                    b3,
    input  logic [CW-1:0]                 column,
    input  logic [CW-1:0]                 row,
    output logic [tupc_pkg::ADDR_W-1:0]   addr,
    output logic [7:0]                    o0,
    output logic [7:0]                    o1,
    output logic [7:0]                    o2,
    output logic [7:0]                    o3
);
    import tupc_pkg::*;

    localparam int YW = ((CW > 12) ? CW : 12) + 1;

    logic [9:0]        rgb_sum;
    logic [19:0]       lum_prod;
    logic [7:0]        lum;
    logic [YW-1:0]     y_pos;
    logic [YW-1:0]     x_pos;
    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] col_off;

    assign rgb_sum  = 10'(b0) + 10'(b1) + 10'(b2);
    assign lum_prod = 20'(rgb_sum) * THIRD_MUL;
    assign lum      = lum_prod[THIRD_SHIFT +: 8];

    always_comb
    begin
        o0 = 8'd0;
        o1 = 8'd0;
        o2 = 8'd0;
        o3 = 8'd0;
        if (cfg.dst_format == DST_ARGB)
        begin
            case (cfg.src_format)
                SRC_LUM:
                begin
                    o0 = b0;
                    o1 = b0;
                    o2 = b0;
                    o3 = b0;
                end
                SRC_RGB:
                begin
                    o0 = OPAQUE_ALPHA;
                    o1 = b0;
                    o2 = b1;
                    o3 = b2;
                end
                default:
                begin
                    // rgba, and the unused code read as rgba
                    o0 = b3;
                    o1 = b0;
                    o2 = b1;
                    o3 = b2;
                end
            endcase
        end
        else
        begin
            o0 = (cfg.src_format == SRC_LUM) ? b0 : lum;
        end
    end

    assign y_pos    = YW'(cfg.y_offset) + YW'(row);
    assign x_pos    = YW'(cfg.x_offset) + YW'(column);
    assign row_base = ADDR_W'(y_pos * cfg.row_pitch);
    assign col_off  = (cfg.dst_format == DST_ARGB) ? ADDR_W'({x_pos, 2'b00})
                                                   : ADDR_W'(x_pos);
    assign addr     = row_base + col_off;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for texture_upload_pixel_converter
// ----------------------------------------------------------------------------
// Pixel beats go in through the valid/stall input channel. An internal
// predictor keeps its own copy of the registers and of the column/row walk,
// and works out the result of each accepted beat. The check process matches
// each result beat against the oldest prediction, field by field. Directed
// tests cover reset values, every layout pair, region clamps, shrinking a
// region mid-walk and address wrap. Random phases then follow with fresh
// register settings. Random bursts of idle on both sides run through the
// directed tests and most random phases, but not the last part of the run.
// ----------------------------------------------------------------------------
module tb;

    import tupc_pkg::*;

    localparam int MAX_DIM      = 4096;
    localparam int RANDOM_ITEMS = 500;
    localparam int CALM_TAIL    = 80;
    localparam int CYCLE_LIMIT  = 400000;

    // one converted pixel as it leaves the block
    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [7:0]        byte0;
        logic [7:0]        byte1;
        logic [7:0]        byte2;
        logic [7:0]        byte3;
        logic              wide;
        logic              done;
    } pixel_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            byte_zero;
    logic [7:0]            byte_one;
    logic [7:0]            byte_two;
    logic [7:0]            byte_three;
    logic                  out_valid;
    logic                  out_stall;
    logic [ADDR_W-1:0]     dest_address;
    logic [7:0]            out_zero;
    logic [7:0]            out_one;
    logic [7:0]            out_two;
    logic [7:0]            out_three;
    logic                  wide_write;
    logic                  region_done;

    // predictor state: shadow registers and the region walk counters
    cfg_t                  shadow_cfg;
    logic [11:0]           column_pos;
    logic [11:0]           row_pos;

    // converted pixels still owed by the block, oldest first
    pixel_result_t         pending_pixels[$];

    bit                    idle_enabled;
    int                    stall_left;
    int                    error_count;
    int                    cycle_count;
    int                    pixels_sent;
    int                    pixels_checked;
    int                    regions_programmed;
    int                    done_seen;

    texture_upload_pixel_converter #(
        .MAX_DIM (MAX_DIM)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_zero    (byte_zero),
        .byte_one     (byte_one),
        .byte_two     (byte_two),
        .byte_three   (byte_three),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dest_address (dest_address),
        .out_zero     (out_zero),
        .out_one      (out_one),
        .out_two      (out_two),
        .out_three    (out_three),
        .wide_write   (wide_write),
        .region_done  (region_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t  timeout with %0d results outstanding", $time,
                     pending_pixels.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // result side backpressure: random stall bursts of random length
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_enabled && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 11);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // out-of-range region sizes are pulled back into 1..MAX_DIM
    function automatic int dim_clamp(input logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // converts one pixel under the shadow registers and steps the walk
    function automatic pixel_result_t convert_pixel(input logic [7:0] b0,
                                                    input logic [7:0] b1,
                                                    input logic [7:0] b2,
                                                    input logic [7:0] b3);
        pixel_result_t     r;
        int                w;
        int                h;
        int                bpp;
        int                lum;
        bit                last_col;
        bit                last_row;
        longint unsigned   addr;

        w   = dim_clamp(shadow_cfg.region_width);
        h   = dim_clamp(shadow_cfg.region_height);
        bpp = (shadow_cfg.dst_format == DST_ARGB) ? 4 : 1;

        r.byte1 = 8'h00;
        r.byte2 = 8'h00;
        r.byte3 = 8'h00;
        if (shadow_cfg.dst_format == DST_ARGB)
        begin
            case (shadow_cfg.src_format)
                SRC_LUM:
                begin
                    r.byte0 = b0;
                    r.byte1 = b0;
                    r.byte2 = b0;
                    r.byte3 = b0;
                end
                SRC_RGB:
                begin
                    r.byte0 = OPAQUE_ALPHA;
                    r.byte1 = b0;
                    r.byte2 = b1;
                    r.byte3 = b2;
                end
                // rgba, and the unused layout code behaves the same
                default:
                begin
                    r.byte0 = b3;
                    r.byte1 = b0;
                    r.byte2 = b1;
                    r.byte3 = b2;
                end
            endcase
        end
        else if (shadow_cfg.src_format == SRC_LUM)
        begin
            r.byte0 = b0;
        end
        else
        begin
            lum     = (int'(b0) + int'(b1) + int'(b2)) / 3;
            r.byte0 = lum[7:0];
        end

        addr = (longint'(shadow_cfg.y_offset) + longint'(row_pos))
                   * longint'(shadow_cfg.row_pitch)
             + (longint'(shadow_cfg.x_offset) + longint'(column_pos)) * bpp;
        r.address = addr[ADDR_W-1:0];

        // a counter past the end of a shrunk region counts as the end
        last_col = int'(column_pos) >= w - 1;
        last_row = int'(row_pos) >= h - 1;
        r.wide   = shadow_cfg.dst_format;
        r.done   = last_col && last_row;

        if (last_col)
        begin
            column_pos = '0;
            row_pos    = last_row ? 12'd0 : row_pos + 12'd1;
        end
        else
        begin
            column_pos = column_pos + 12'd1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t  %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t  unexpected result beat: expected none, actual addr 0x%0h",
                         $time, dest_address);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("dest_address", want.address, dest_address);
                check_field("out_zero", want.byte0, out_zero);
                check_field("out_one", want.byte1, out_one);
                check_field("out_two", want.byte2, out_two);
                check_field("out_three", want.byte3, out_three);
                check_field("wide_write", want.wide, wide_write);
                check_field("region_done", want.done, region_done);
                pixels_checked++;
                if (want.done)
                    done_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one register write; the caller lowers the strobe after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_SRC_FORMAT:    shadow_cfg.src_format    = value[1:0];
            REG_DST_FORMAT:    shadow_cfg.dst_format    = value[0];
            REG_REGION_WIDTH:  shadow_cfg.region_width  = value[DIM_W-1:0];
            REG_REGION_HEIGHT: shadow_cfg.region_height = value[DIM_W-1:0];
            REG_X_OFFSET:      shadow_cfg.x_offset      = value[11:0];
            REG_Y_OFFSET:      shadow_cfg.y_offset      = value[11:0];
            REG_ROW_PITCH:     shadow_cfg.row_pitch     = value[14:0];
            default:           ;
        endcase
    endtask

    task automatic finish_writes;
        cfg_write <= 1'b0;
    endtask

    // writes every register for a new upload setting
    task automatic program_region(input int src, input int dst, input int w,
                                  input int h, input int x, input int y,
                                  input int pitch);
        write_reg(REG_SRC_FORMAT, CFG_DATA_W'(src));
        write_reg(REG_DST_FORMAT, CFG_DATA_W'(dst));
        write_reg(REG_REGION_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_REGION_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_X_OFFSET, CFG_DATA_W'(x));
        write_reg(REG_Y_OFFSET, CFG_DATA_W'(y));
        write_reg(REG_ROW_PITCH, CFG_DATA_W'(pitch));
        finish_writes();
        regions_programmed++;
    endtask

    // drives one pixel beat, waits for it to be taken, maybe idles after
    task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
        in_valid   <= 1'b1;
        byte_zero  <= b0;
        byte_one   <= b1;
        byte_two   <= b2;
        byte_three <= b3;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_pixels.push_back(convert_pixel(b0, b1, b2, b3));
        pixels_sent++;
        if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // sender holds off until every owed result is back, then lets the
    // two-stage pipe settle before registers change
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // byte values lean toward the extremes now and then
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset setting: rgba in, argb out, a single-pixel region at pitch 4
    task automatic test_reset_state;
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
        drain();
    endtask

    // every source/destination pair, including the unused source code
    task automatic test_layouts;
        logic [31:0] patterns[4];
        logic [31:0] pat;
        patterns = '{32'hffffff00, 32'h000000ff, 32'h010100a5, 32'h807f015a};
        for (int src = 0; src < 4; src++)
        begin
            for (int dst = 0; dst < 2; dst++)
            begin
                program_region(src, dst, 1, 1, 0, 0, 4);
                pat = patterns[(src * 2 + dst) % 4];
                send_pixel(pat[31:24], pat[23:16], pat[15:8], pat[7:0]);
                drain();
            end
        end
    endtask

    // a 2x2 walk with offsets, then a zero-sized region taken as 1x1
    task automatic test_region_walk;
        program_region(SRC_RGB, DST_ARGB, 2, 2, 3, 1, 100);
        repeat (4) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
        drain();
        program_region(SRC_LUM, DST_LUM, 0, 0, 4095, 0, 0);
        send_pixel(8'h5a, 8'ha5, 8'h3c, 8'hc3);
        drain();
    endtask

    // region made smaller while the counters sit past its new end
    task automatic test_region_shrink;
        program_region(SRC_RGBA, DST_LUM, 1, 8, 0, 0, 16);
        repeat (3) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
        drain();
        write_reg(REG_REGION_HEIGHT, CFG_DATA_W'(2));
        finish_writes();
        send_pixel(8'hff, 8'hff, 8'hfe, 8'h01);
        drain();
        program_region(SRC_RGBA, DST_ARGB, 8, 1, 0, 0, 16);
        repeat (3) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
        drain();
        write_reg(REG_REGION_WIDTH, CFG_DATA_W'(3));
        finish_writes();
        send_pixel(8'h11, 8'h22, 8'h33, 8'h44);
        drain();
    endtask

    // largest offsets and pitch: the second row runs past 27 bits
    task automatic test_address_wrap;
        program_region(SRC_RGB, DST_ARGB, 1, 2, 4095, 4095, 32767);
        send_pixel(8'h01, 8'h02, 8'h03, 8'h04);
        send_pixel(8'hfe, 8'hfd, 8'hfc, 8'hfb);
        drain();
    endtask

    // phases of random pixels, each under a fresh register setting; most
    // regions are small so the walk wraps often, a few use the full range
    task automatic test_random_regions;
        int sent;
        int phase_len;
        int phase;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(20, 60);
            if (sent + phase_len > RANDOM_ITEMS)
                phase_len = RANDOM_ITEMS - sent;
            // the tail of the run streams without any idle
            idle_enabled = (RANDOM_ITEMS - sent > CALM_TAIL) && ($urandom_range(0, 3) != 0);
            case (phase % 6)
                0: program_region(SRC_LUM, DST_LUM, 0, 0, 0, 0, 0);
                1: program_region(3, DST_ARGB, 8191, 8191, 4095, 4095, 32767);
                5: program_region($urandom_range(0, 3), $urandom_range(0, 1),
                                  $urandom_range(0, 8191), $urandom_range(0, 8191),
                                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                                  $urandom_range(0, 32767));
                default: program_region($urandom_range(0, 3), $urandom_range(0, 1),
                                        $urandom_range(0, 8), $urandom_range(1, 6),
                                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                                        $urandom_range(0, 32767));
            endcase
            repeat (phase_len)
                send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
            drain();
            sent += phase_len;
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        byte_zero    <= '0;
        byte_one     <= '0;
        byte_two     <= '0;
        byte_three   <= '0;
        shadow_cfg   = CFG_RESET;
        column_pos   = '0;
        row_pos      = '0;
        idle_enabled = 1'b1;
        stall_left   = 0;
        error_count  = 0;
        cycle_count  = 0;
        pixels_sent  = 0;
        pixels_checked     = 0;
        regions_programmed = 0;
        done_seen          = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_layouts();
        test_region_walk();
        test_region_shrink();
        test_address_wrap();
        test_random_regions();

        // nothing owed any more; keep the clock running so the pipe can show any
        // stray result beat
        drain();
        repeat (8) @(posedge clk);

        $display("%0d pixel beats over %0d register settings, %0d results compared",
                 pixels_sent, regions_programmed, pixels_checked);
        $display("%0d region ends seen; all layout pairs, clamps, shrinks and wrap hit",
                 done_seen);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tupc_pkg.sv
rtl/core/tupc_walker.sv
rtl/core/tupc_datapath.sv
rtl/core/texture_upload_pixel_converter.sv
tb/sv/tb.sv
